// ===== rtl/terrain_patch_lod_select_unit_defines.svh =====
// assertion macros for the terrain patch lod select unit
// depends on clk and rst_n in the scope of use
`ifndef TERRAIN_PATCH_LOD_SELECT_UNIT_DEFINES_SVH
`define TERRAIN_PATCH_LOD_SELECT_UNIT_DEFINES_SVH

// implication checked every clock outside reset
`define TPLS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// implication checked on the following clock
`define TPLS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/tpls_pkg.sv =====
// shared types, constants and helpers for the terrain patch lod select unit
// no dependencies
package tpls_pkg;

  localparam int MAX_PATCHES_PER_SIDE = 64;
  localparam int MAX_LEVELS = 8;

  localparam logic [2:0] REG_SEGMENTS_LOG2 = 3'd0;
  localparam logic [2:0] REG_PATCHES_X = 3'd1;
  localparam logic [2:0] REG_PATCHES_Z = 3'd2;
  localparam logic [2:0] REG_WORLD_SCALE = 3'd3;
  localparam logic [2:0] REG_FAR_PLANE = 3'd4;
  localparam logic [2:0] REG_COUNT = 3'd5;

  localparam int DIV_BITS = 34;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_IDLE
  } state_t;

  // five times the triangular number of the level count
  function automatic logic [7:0] band_divisor(input logic [3:0] levels);
    logic [7:0] d;
    case (levels)
      4'd1: d = 8'd5;
      4'd2: d = 8'd15;
      4'd3: d = 8'd30;
      4'd4: d = 8'd50;
      4'd5: d = 8'd75;
      4'd6: d = 8'd105;
      4'd7: d = 8'd140;
      4'd8: d = 8'd180;
      default: d = 8'd5;
    endcase
    return d;
  endfunction

  // magnitude saturated at 2^24
  function automatic logic [24:0] abs_sat(input logic signed [32:0] d);
    logic [32:0] a;
    a = d[32] ? 33'(-d) : 33'(d);
    return (a > 33'h1000000) ? 25'h1000000 : a[24:0];
  endfunction

endpackage

// ===== rtl/terrain_patch_lod_select_unit.sv =====
// input beats pass registered stages to the output beat, one beat per cycle sustained
// outside rebuilds and stalls; a stall on out_tready holds all stages and drops in_tready
// band table rebuild after reset and after each register write: a load step,
// a 34-step serial divider, then 8 accumulate steps, with in_tready low
// rst_n is synchronous active low; registers return to their reset values
module terrain_patch_lod_select_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // camera_x[31:0], camera_y[63:32], camera_z[95:64], patch_col[101:96],
  // patch_row[107:102], zero pad
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // core_level[2:0], left_coarser[3], right_coarser[4], bottom_coarser[5],
  // top_coarser[6], index_error[7]
  output logic [7:0]   out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [15:0]  cfg_wdata
);
  import tpls_pkg::*;
`include "terrain_patch_lod_select_unit_defines.svh"

  // configuration
  logic [3:0]  seg_r;
  logic [6:0]  px_cnt_r, pz_cnt_r;
  logic [15:0] scale_r, far_r;
  logic [3:0]  levels;
  logic [6:0]  nx, nz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= 4'd5;
      px_cnt_r <= 7'd16;
      pz_cnt_r <= 7'd16;
      scale_r <= 16'd256;
      far_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SEGMENTS_LOG2: seg_r <= cfg_wdata[3:0];
        REG_PATCHES_X:     px_cnt_r <= cfg_wdata[6:0];
        REG_PATCHES_Z:     pz_cnt_r <= cfg_wdata[6:0];
        REG_WORLD_SCALE:   scale_r <= cfg_wdata;
        REG_FAR_PLANE:     far_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign levels = (seg_r == 4'd0) ? 4'd1 :
                  (seg_r > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : seg_r;
  assign nx = (px_cnt_r > 7'(MAX_PATCHES_PER_SIDE)) ? 7'(MAX_PATCHES_PER_SIDE) : px_cnt_r;
  assign nz = (pz_cnt_r > 7'(MAX_PATCHES_PER_SIDE)) ? 7'(MAX_PATCHES_PER_SIDE) : pz_cnt_r;

  // band table rebuild
  state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        cfg_hit;
  logic [33:0] nq_r;
  logic [7:0]  rem_r, div_r;
  logic [31:0] m_r;
  logic [15:0] acc_r;
  logic [31:0] bsq_r [MAX_LEVELS];
  logic [8:0]  trial;
  logic        ge;
  logic [15:0] band;

  assign cfg_hit = cfg_we && (cfg_addr < REG_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_LOAD: begin
        state_nxt = ST_DIV;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_BITS - 1)) begin
          state_nxt = ST_ACC;
          cnt_nxt = '0;
        end
      end
      ST_ACC: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MAX_LEVELS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: ;
      default: state_nxt = ST_LOAD;
    endcase
    if (cfg_hit) state_nxt = ST_LOAD;
  end

  assign trial = {rem_r, nq_r[33]};
  assign ge = trial >= {1'b0, div_r};
  assign band = acc_r + m_r[31:16];

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        nq_r <= {18'(far_r) * 18'd3, 16'd0};
        rem_r <= '0;
        div_r <= band_divisor(levels);
      end
      ST_DIV: begin
        rem_r <= ge ? 8'(trial - {1'b0, div_r}) : trial[7:0];
        nq_r <= {nq_r[32:0], ge};
        m_r <= {nq_r[30:0], ge};
        acc_r <= '0;
      end
      ST_ACC: begin
        bsq_r[cnt_r[2:0]] <= ({1'b0, cnt_r[2:0]} < levels) ? 32'(band) * 32'(band) : 32'd0;
        acc_r <= band;
        m_r <= m_r + nq_r[31:0];
      end
      default: ;
    endcase
  end

  // query pipeline
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r} <= '0;
    end else if (adv) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // stage 1: patch centres
  logic [5:0]  col, row;
  logic [6:0]  xi [3];
  logic [6:0]  zi [3];
  logic [3:0]  nb_ok;
  logic        err;
  logic [30:0] cpx [3];
  logic [30:0] cpz [3];

  assign col = in_tdata[101:96];
  assign row = in_tdata[107:102];
  assign xi[0] = {1'b0, col} - 7'd1;
  assign xi[1] = {1'b0, col};
  assign xi[2] = {1'b0, col} + 7'd1;
  assign zi[0] = {1'b0, row} - 7'd1;
  assign zi[1] = {1'b0, row};
  assign zi[2] = {1'b0, row} + 7'd1;
  assign err = ({1'b0, col} >= nx) || ({1'b0, row} >= nz);
  assign nb_ok = {zi[2] < nz, row != 6'd0, xi[2] < nx, col != 6'd0};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cpx[k] = 31'((16'(xi[k]) << levels) + (16'd1 << (levels - 4'd1))) * 31'(scale_r);
      cpz[k] = 31'((16'(zi[k]) << levels) + (16'd1 << (levels - 4'd1))) * 31'(scale_r);
    end
  end

  logic [31:0] cx1_r, cy1_r, cz1_r;
  logic [30:0] px1_r [3];
  logic [30:0] pz1_r [3];
  logic [3:0]  ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;
  logic        err1_r, err2_r, err3_r, err4_r, err5_r;

  // stage 2: axis distances
  logic [24:0] ax2_r [3];
  logic [24:0] az2_r [3];
  logic [24:0] ay2_r;
  // stage 3: squares
  logic [48:0] sx3_r [3];
  logic [48:0] sz3_r [3];
  logic [48:0] sy3_r;
  // stage 4: squared distances, scaled down by 2^16
  logic [34:0] d4_r [5];
  logic [50:0] d2 [5];
  // stage 5: levels, order core, left, right, bottom, top
  logic [2:0]  lv5_r [5];
  logic [2:0]  lv [5];
  logic [7:0]  out_r;

  always_comb begin
    d2[0] = 51'(sx3_r[1]) + 51'(sy3_r) + 51'(sz3_r[1]);
    d2[1] = 51'(sx3_r[0]) + 51'(sy3_r) + 51'(sz3_r[1]);
    d2[2] = 51'(sx3_r[2]) + 51'(sy3_r) + 51'(sz3_r[1]);
    d2[3] = 51'(sx3_r[1]) + 51'(sy3_r) + 51'(sz3_r[0]);
    d2[4] = 51'(sx3_r[1]) + 51'(sy3_r) + 51'(sz3_r[2]);
  end

  always_comb begin
    for (int p = 0; p < 5; p++) begin
      lv[p] = 3'(levels - 4'd1);
      for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
        if (d4_r[p] < 35'(bsq_r[i])) lv[p] = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx1_r <= in_tdata[31:0];
      cy1_r <= in_tdata[63:32];
      cz1_r <= in_tdata[95:64];
      px1_r <= cpx;
      pz1_r <= cpz;
      ok1_r <= nb_ok;
      err1_r <= err;
      for (int k = 0; k < 3; k++) begin
        ax2_r[k] <= abs_sat(33'($signed(cx1_r)) - $signed({2'b00, px1_r[k]}));
        az2_r[k] <= abs_sat(33'($signed(cz1_r)) - $signed({2'b00, pz1_r[k]}));
        sx3_r[k] <= 49'(ax2_r[k]) * 49'(ax2_r[k]);
        sz3_r[k] <= 49'(az2_r[k]) * 49'(az2_r[k]);
      end
      ay2_r <= abs_sat(33'($signed(cy1_r)));
      sy3_r <= 49'(ay2_r) * 49'(ay2_r);
      for (int p = 0; p < 5; p++) begin
        d4_r[p] <= d2[p][50:16];
      end
      lv5_r <= lv;
      ok2_r <= ok1_r;
      ok3_r <= ok2_r;
      ok4_r <= ok3_r;
      ok5_r <= ok4_r;
      err2_r <= err1_r;
      err3_r <= err2_r;
      err4_r <= err3_r;
      err5_r <= err4_r;
      if (err5_r) begin
        out_r <= 8'h80;
      end else begin
        out_r <= {1'b0,
                  ok5_r[3] && (lv5_r[4] > lv5_r[0]),
                  ok5_r[2] && (lv5_r[3] > lv5_r[0]),
                  ok5_r[1] && (lv5_r[2] > lv5_r[0]),
                  ok5_r[0] && (lv5_r[1] > lv5_r[0]),
                  lv5_r[0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_r;

  `TPLS_ASSERT_IMP(a_accept_idle, in_tvalid && in_tready, state_r == ST_IDLE, "beat accepted during band rebuild")
  `TPLS_ASSERT_NEXT(a_cfg_rebuild, cfg_hit, state_r == ST_LOAD, "register write did not restart band rebuild")
  `TPLS_ASSERT_IMP(a_err_clean, out_tvalid && out_tdata[7], out_tdata[6:0] == 7'd0, "index error beat carries data")
  `TPLS_ASSERT_IMP(a_level_range, out_tvalid && !out_tdata[7], {1'b0, out_tdata[2:0]} < levels, "level beyond maximum")

endmodule

// ===== sim/terrain_patch_lod_select_unit_test.sv =====
// testbench for the terrain patch lod select unit: random and directed queries
// checked against a behavioral predictor; depends on tpls_pkg and the rtl top
module terrain_patch_lod_select_unit_test;
  import tpls_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [7:0]   out_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;

  terrain_patch_lod_select_unit u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic [3:0]  seg_q = 5;
  logic [6:0]  px_q = 16, pz_q = 16;
  logic [15:0] scale_q = 256, far_q = 1000;
  logic [15:0] bounds[8];

  logic [7:0] lod_expected[$];
  int errors = 0, n_sent = 0, n_checked = 0;
  int hold_long = 0;
  int rx_wait = 0;
  bit  rx_stall_en = 1;

  function automatic int levels_eff();
    int s = seg_q;
    if (s < 1) s = 1;
    if (s > MAX_LEVELS) s = MAX_LEVELS;
    return s;
  endfunction

  function automatic void build_bands();
    int lv = levels_eff();
    longint unsigned sum = lv * (lv + 1) / 2;
    longint unsigned stp = (longint'(far_q) * 3 * 65536) / (5 * sum);
    longint unsigned acc = 0;
    for (int i = 0; i < 8; i++) begin
      if (i < lv) begin
        acc += (stp * (i + 1)) >> 16;
        bounds[i] = acc[15:0];
      end else bounds[i] = 0;
    end
  endfunction

  function automatic longint unsigned sq_clip(longint d);
    longint unsigned a = (d < 0) ? -d : d;
    if (a > (64'd1 << 24)) a = 64'd1 << 24;
    return a * a;
  endfunction

  function automatic int patch_level(longint cx, longint cy, longint cz, int col, int row);
    int lv = levels_eff();
    longint ctr_x = ((longint'(col) << lv) + (1 << (lv - 1))) * longint'(scale_q);
    longint ctr_z = ((longint'(row) << lv) + (1 << (lv - 1))) * longint'(scale_q);
    longint unsigned d2 = sq_clip(cx - ctr_x) + sq_clip(cy) + sq_clip(cz - ctr_z);
    longint unsigned b;
    for (int i = 0; i < lv; i++) begin
      b = longint'(bounds[i]) * 256;
      if (d2 < b * b) return i;
    end
    return lv - 1;
  endfunction

  function automatic logic [7:0] predict_lod(logic [111:0] d);
    longint cx = $signed(d[31:0]), cy = $signed(d[63:32]), cz = $signed(d[95:64]);
    int col = d[101:96], row = d[107:102];
    int nx = (px_q > MAX_PATCHES_PER_SIDE) ? MAX_PATCHES_PER_SIDE : px_q;
    int nz = (pz_q > MAX_PATCHES_PER_SIDE) ? MAX_PATCHES_PER_SIDE : pz_q;
    logic [7:0] r = '0;
    int core;
    if (col >= nx || row >= nz) begin
      r[7] = 1;
      return r;
    end
    core = patch_level(cx, cy, cz, col, row);
    r[2:0] = 3'(core);
    r[3] = col > 0 && patch_level(cx, cy, cz, col - 1, row) > core;
    r[4] = col + 1 < nx && patch_level(cx, cy, cz, col + 1, row) > core;
    r[5] = row > 0 && patch_level(cx, cy, cz, col, row - 1) > core;
    r[6] = row + 1 < nz && patch_level(cx, cy, cz, col, row + 1) > core;
    return r;
  endfunction

  // in_tvalid stays high after a beat until the next one or a pause
  task automatic send_query(logic [31:0] cx, cy, cz, logic [5:0] col, row, bit gaps = 1);
    int gap = gaps ? $urandom_range(0, 6) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {4'b0, row, col, cz, cy, cx};
    in_tvalid <= 1;
    lod_expected.push_back(predict_lod({4'b0, row, col, cz, cy, cx}));
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // receiver: random wait per beat, long hold-off on request, always ready when stalls are off
  always @(posedge clk) begin
    int w;
    w = $urandom_range(0, 6);
    if (!rst_n) begin
      out_tready <= 0;
      rx_wait <= 0;
    end else if (hold_long > 0) begin
      out_tready <= 0;
      hold_long <= hold_long - 1;
    end else if (!rx_stall_en) out_tready <= 1;
    else if (out_tready && out_tvalid) begin
      out_tready <= (w == 0);
      rx_wait <= w;
    end else if (rx_wait > 0) begin
      out_tready <= (rx_wait == 1);
      rx_wait <= rx_wait - 1;
    end else out_tready <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (lod_expected.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, out_tdata);
        errors++;
      end else begin
        logic [7:0] e;
        e = lod_expected.pop_front();
        if (e !== out_tdata) begin
          $display({"%0t mismatch: expected lvl=%0d l=%b r=%b b=%b t=%b err=%b, ",
                    "actual lvl=%0d l=%b r=%b b=%b t=%b err=%b"},
                   $time, e[2:0], e[3], e[4], e[5], e[6], e[7],
                   out_tdata[2:0], out_tdata[3], out_tdata[4], out_tdata[5], out_tdata[6],
                   out_tdata[7]);
          errors++;
        end
        n_checked++;
      end
    end
  end

  task automatic drain();
    in_tvalid <= 0;
    while (lod_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_SEGMENTS_LOG2: seg_q = val[3:0];
      REG_PATCHES_X: px_q = val[6:0];
      REG_PATCHES_Z: pz_q = val[6:0];
      REG_WORLD_SCALE: scale_q = val;
      REG_FAR_PLANE: far_q = val;
      default: ;
    endcase
    build_bands();
  endtask

  // camera mostly near the grid so levels spread over all bands; some queries fully random
  task automatic random_query(bit gaps = 1);
    int span = (MAX_PATCHES_PER_SIDE << levels_eff()) * scale_q;
    logic [31:0] cx, cy, cz;
    int m = $urandom_range(0, 9);
    if (m == 0) begin
      cx = $urandom; cy = $urandom; cz = $urandom;
    end else begin
      cx = $urandom_range(0, span + 10) - 5;
      cz = $urandom_range(0, span + 10) - 5;
      cy = (m < 4) ? 0 : $urandom_range(0, 32'h40000) - 32'h20000;
    end
    send_query(cx, cy, cz,
               ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, px_q)),
               ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, pz_q)),
               gaps);
  endtask

  task automatic test_directed();
    send_query(0, 0, 0, 0, 0);
    send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 15, 15);
    send_query(32'h80000000, 32'h80000000, 32'h80000000, 63, 63);
    send_query(32'hffffffff, 0, 32'hffffffff, 7, 8);
    send_query(32'h3000, 0, 32'h3000, 1, 1);
    send_query(32'h1000, 32'h100, 32'h1000, 0, 15);
    send_query(32'h2000, 0, 32'h2000, 16, 0);
    send_query(32'h2000, 0, 32'h2000, 0, 16);
    for (int i = 0; i < 8; i++) send_query(i * 32'h1000, 0, 32'h800, i, 0);
  endtask

  task automatic test_config_sweep();
    logic [15:0] segs[5] = '{0, 1, 8, 15, 3};
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_SEGMENTS_LOG2, segs[k]);
      write_reg(REG_PATCHES_X, (k == 1) ? 1 : (k == 2) ? 64 : (k == 3) ? 127 : 0);
      write_reg(REG_PATCHES_Z, (k == 1) ? 1 : (k == 2) ? 64 : (k == 3) ? 100 : 5);
      write_reg(REG_WORLD_SCALE, (k == 2) ? 16'hffff : (k == 1) ? 1 : 16'($urandom_range(1, 2000)));
      write_reg(REG_FAR_PLANE, (k == 2) ? 16'hffff : (k == 1) ? 1 : (k == 4) ? 0 : 16'($urandom_range(50, 5000)));
      repeat (60) random_query();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_SEGMENTS_LOG2, 5);
    write_reg(REG_PATCHES_X, 16);
    write_reg(REG_PATCHES_Z, 16);
    write_reg(REG_WORLD_SCALE, 256);
    write_reg(REG_FAR_PLANE, 1000);
    hold_long = 80;
    repeat (40) random_query(0);
    drain();
    rx_stall_en = 0;
    repeat (100) random_query(0);
    rx_stall_en = 1;
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SEGMENTS_LOG2, $urandom_range(1, 8));
      write_reg(REG_PATCHES_X, $urandom_range(1, 64));
      write_reg(REG_PATCHES_Z, $urandom_range(1, 64));
      write_reg(REG_WORLD_SCALE, $urandom_range(1, 1024));
      write_reg(REG_FAR_PLANE, $urandom_range(100, 65535));
      repeat (200) random_query();
    end
  endtask

  initial begin
    build_bands();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    $display("sent %0d queries over edge, oversized and random grid and band settings,",
             n_sent);
    $display("with long output hold-off and full-rate bursts; %0d results checked",
             n_checked);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tpls_pkg.sv
rtl/terrain_patch_lod_select_unit.sv
sim/terrain_patch_lod_select_unit_test.sv
